// File: hw/rtl/pch_pkg.sv
// Package for the per-channel histogram core: transfer types, command type,
// sequencer states and default sizes. Used by pch_front, pch_back and the core top level.
`default_nettype none

package pch_pkg;

  // default sizes handed to the top-level parameters
  localparam int BIN_COUNT_DEF     = 10;
  localparam int CHANNEL_COUNT_DEF = 12;
  localparam int COUNT_WIDTH_DEF   = 16;

  // fraction bits of the unsigned Q1.16 sample
  localparam int FRAC_W = 16;

  // operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // one input transfer
  typedef struct packed {
    logic        operation;
    logic [3:0]  channel;
    logic [16:0] sample_value;
    logic [3:0]  bin_index;
  } pch_item_t;

  // one result transfer
  typedef struct packed {
    logic [15:0] channel_count;
    logic [15:0] total_count;
    logic [3:0]  bin_used;
    logic        out_of_range;
  } pch_result_t;

  // classified command passed from the front end to the update engine
  typedef struct packed {
    logic       write_en;      // bump both counters
    logic       chan_sel;      // report the channel counter
    logic       total_sel;     // report the global counter
    logic       out_of_range;
    logic [3:0] bin_used;
  } pch_cmd_t;

  // update engine sequencer
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } pch_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/pch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/pch_front.sv
// Front end: takes input transfers, works out the bin and counter address
// and the command for the update engine. Depends on pch_pkg.
`default_nettype none

module pch_front #(
  parameter int BIN_COUNT     = pch_pkg::BIN_COUNT_DEF,
  parameter int CHANNEL_COUNT = pch_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                                      item_valid,
  output logic                                           item_stall,
  input  wire pch_pkg::pch_item_t                        item,
  input  wire logic                                      queue_full,
  input  wire logic                                      clearing,
  output logic                                           push,
  output pch_pkg::pch_cmd_t                              cmd,
  output logic [$clog2(CHANNEL_COUNT*BIN_COUNT)-1:0]     addr,
  output logic [$clog2(BIN_COUNT)-1:0]                   bin
);

  import pch_pkg::*;

  localparam int BW = $clog2(BIN_COUNT);
  localparam int AW = $clog2(CHANNEL_COUNT * BIN_COUNT);
  localparam int PW = FRAC_W + BW;

  logic [PW-1:0] prod;
  logic [BW-1:0] add_bin;
  logic [BW-1:0] sel_bin;
  logic          above_one;
  logic          chan_ok;
  logic          read_bin_ok;

  // handshake: hold off while the queue is full or the counters are clearing
  assign item_stall = queue_full || clearing;
  assign push       = item_valid && !item_stall;

  // bin = floor(sample * BIN_COUNT) for samples below one
  assign prod      = PW'(item.sample_value[FRAC_W-1:0]) * PW'(BIN_COUNT);
  assign add_bin   = prod[PW-1:FRAC_W];
  assign above_one = item.sample_value[FRAC_W];

  assign chan_ok     = int'(item.channel) < CHANNEL_COUNT;
  assign read_bin_ok = int'(item.bin_index) < BIN_COUNT;

  // classify the transfer
  always_comb begin
    cmd     = '0;
    sel_bin = add_bin;
    if (item.operation == OP_ADD) begin
      cmd.out_of_range = above_one;
      cmd.total_sel    = !above_one;
      cmd.write_en     = !above_one && chan_ok;
      cmd.chan_sel     = !above_one && chan_ok;
      cmd.bin_used     = above_one ? 4'd0 : 4'(add_bin);
    end else begin
      cmd.total_sel = read_bin_ok;
      cmd.chan_sel  = read_bin_ok && chan_ok;
      cmd.bin_used  = item.bin_index;
      sel_bin       = read_bin_ok ? BW'(item.bin_index) : '0;
    end
  end

  // counter addresses, kept inside the stores when unused
  assign bin  = sel_bin;
  assign addr = cmd.chan_sel ? AW'(int'(item.channel) * BIN_COUNT + int'(sel_bin)) : '0;

endmodule

`default_nettype wire

// File: hw/rtl/pch_queue.sv
// Two-entry queue between the front end and the update engine.
// Depends on nothing but its width parameter.
`default_nettype none

module pch_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output logic      [WIDTH-1:0] head
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [1:0]       count_next;

  assign count_next = count + 2'(push) - 2'(pop);
  assign full       = count == 2'd2;
  assign empty      = count == 2'd0;
  assign head       = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

// File: hw/rtl/pch_back.sv
// Update engine: clears the counter stores after reset, then runs one read per
// command, with a write-back when it bumps counters, and holds the result. Depends on pch_pkg, pch_ram.
`default_nettype none

module pch_back #(
  parameter int BIN_COUNT     = pch_pkg::BIN_COUNT_DEF,
  parameter int CHANNEL_COUNT = pch_pkg::CHANNEL_COUNT_DEF,
  parameter int COUNT_WIDTH   = pch_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      queue_empty,
  input  wire pch_pkg::pch_cmd_t                         head_cmd,
  input  wire logic [$clog2(CHANNEL_COUNT*BIN_COUNT)-1:0] head_addr,
  input  wire logic [$clog2(BIN_COUNT)-1:0]              head_bin,
  output logic                                           pop,
  output logic                                           clearing,
  output logic                                           result_valid,
  input  wire logic                                      result_stall,
  output pch_pkg::pch_result_t                           result
);

  import pch_pkg::*;

  localparam int DEPTH = CHANNEL_COUNT * BIN_COUNT;
  localparam int BW    = $clog2(BIN_COUNT);
  localparam int AW    = $clog2(DEPTH);

  pch_state_t       state;
  pch_state_t       state_next;
  logic [AW-1:0]    clr_addr;
  pch_cmd_t         cur_cmd;
  logic [AW-1:0]    cur_addr;
  logic [BW-1:0]    cur_bin;

  logic             chan_we;
  logic [AW-1:0]    chan_waddr;
  logic [COUNT_WIDTH-1:0] chan_wdata;
  logic [COUNT_WIDTH-1:0] chan_rdata;
  logic             tot_we;
  logic [BW-1:0]    tot_waddr;
  logic [COUNT_WIDTH-1:0] tot_wdata;
  logic [COUNT_WIDTH-1:0] tot_rdata;
  logic [COUNT_WIDTH-1:0] chan_bump;
  logic [COUNT_WIDTH-1:0] tot_bump;
  logic             load_out;
  pch_result_t      result_next;

  // counter stores
  pch_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_chan_ram (
    .clk   (clk),
    .we    (chan_we),
    .waddr (chan_waddr),
    .wdata (chan_wdata),
    .raddr (head_addr),
    .rdata (chan_rdata)
  );

  pch_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BIN_COUNT)
  ) u_tot_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .raddr (head_bin),
    .rdata (tot_rdata)
  );

  // saturating increments
  assign chan_bump = (chan_rdata == '1) ? chan_rdata : chan_rdata + COUNT_WIDTH'(1);
  assign tot_bump  = (tot_rdata == '1) ? tot_rdata : tot_rdata + COUNT_WIDTH'(1);

  // result fields from the fresh read data
  always_comb begin
    result_next               = '0;
    result_next.bin_used      = cur_cmd.bin_used;
    result_next.out_of_range  = cur_cmd.out_of_range;
    if (cur_cmd.chan_sel) begin
      result_next.channel_count = cur_cmd.write_en ? 16'(chan_bump) : 16'(chan_rdata);
    end
    if (cur_cmd.total_sel) begin
      result_next.total_count = cur_cmd.write_en ? 16'(tot_bump) : 16'(tot_rdata);
    end
  end

  // state register and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    chan_we    = 1'b0;
    chan_waddr = cur_addr;
    chan_wdata = chan_bump;
    tot_we     = 1'b0;
    tot_waddr  = cur_bin;
    tot_wdata  = tot_bump;
    unique case (state)
      ST_CLEAR: begin
        chan_we    = 1'b1;
        chan_waddr = clr_addr;
        chan_wdata = '0;
        tot_we     = int'(clr_addr) < BIN_COUNT;
        tot_waddr  = BW'(clr_addr);
        tot_wdata  = '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!queue_empty && (!result_valid || !result_stall)) begin
          pop        = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        chan_we    = cur_cmd.write_en;
        tot_we     = cur_cmd.write_en;
        load_out   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign clearing = state == ST_CLEAR;

  // command held while its read is in flight
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_cmd  <= head_cmd;
      cur_addr <= head_addr;
      cur_bin  <= head_bin;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= result_next;
    end
  end

  a_quiet_while_clearing: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !result_valid)
    else $error("result offered during clearing pass");
  a_update_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |=> result_valid)
    else $error("update finished without a result");
  a_no_wrap: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE && cur_cmd.write_en |-> chan_wdata != '0 && tot_wdata != '0)
    else $error("counter wrapped instead of saturating");

endmodule

`default_nettype wire

// File: hw/rtl/per_channel_histogram_core.sv
// Per-channel histogram core. Each add transfer takes an unsigned Q1.16 sample,
// bins it as floor(sample * BIN_COUNT) and, if the channel exists, bumps that
// channel's counter and the global counter of the same bin, both saturating at
// 2^COUNT_WIDTH - 1; samples of 1.0 or more are counted nowhere and flagged
// out_of_range. A read transfer returns one channel counter and the matching
// global counter. Every input transfer gives exactly one result transfer. A front
// end classifies transfers into a two-entry queue; the update engine takes one
// command at a time through a registered RAM read and, for an add, a write-back.
// After reset the counter stores are swept to zero (CHANNEL_COUNT * BIN_COUNT
// channel entries, 120 by default), and item_stall stays high during the sweep.
// Depends on pch_pkg, pch_front, pch_queue, pch_back and pch_ram.
`default_nettype none

module per_channel_histogram_core #(
  parameter int BIN_COUNT     = pch_pkg::BIN_COUNT_DEF,
  parameter int CHANNEL_COUNT = pch_pkg::CHANNEL_COUNT_DEF,
  parameter int COUNT_WIDTH   = pch_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire pch_pkg::pch_item_t   item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output pch_pkg::pch_result_t      result
);

  import pch_pkg::*;

  localparam int BW = $clog2(BIN_COUNT);
  localparam int AW = $clog2(CHANNEL_COUNT * BIN_COUNT);
  localparam int QW = $bits(pch_cmd_t) + AW + BW;

  logic          push;
  logic          pop;
  logic          queue_full;
  logic          queue_empty;
  logic          clearing;
  pch_cmd_t      in_cmd;
  logic [AW-1:0] in_addr;
  logic [BW-1:0] in_bin;
  logic [QW-1:0] head_data;
  pch_cmd_t      head_cmd;
  logic [AW-1:0] head_addr;
  logic [BW-1:0] head_bin;

  // classification
  pch_front #(
    .BIN_COUNT     (BIN_COUNT),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (queue_full),
    .clearing   (clearing),
    .push       (push),
    .cmd        (in_cmd),
    .addr       (in_addr),
    .bin        (in_bin)
  );

  // decoupling queue
  pch_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({in_cmd, in_addr, in_bin}),
    .pop       (pop),
    .full      (queue_full),
    .empty     (queue_empty),
    .head      (head_data)
  );

  assign {head_cmd, head_addr, head_bin} = head_data;

  // counter update and result
  pch_back #(
    .BIN_COUNT     (BIN_COUNT),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_empty  (queue_empty),
    .head_cmd     (head_cmd),
    .head_addr    (head_addr),
    .head_bin     (head_bin),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for per_channel_histogram_core: directed, repeated-bin and random transfers
// checked against a histogram predictor kept in a small scoreboard class.
// Depends on pch_pkg and per_channel_histogram_core.

// predicted histogram stores and the queue of results still owed by the core
class hist_scoreboard;
  localparam int BINS       = pch_pkg::BIN_COUNT_DEF;
  localparam int CHANNELS   = pch_pkg::CHANNEL_COUNT_DEF;
  localparam int COUNT_W    = pch_pkg::COUNT_WIDTH_DEF;
  localparam int ONE_Q16    = 1 << pch_pkg::FRAC_W;
  localparam int REPORT_CAP = 100;

  typedef bit [COUNT_W-1:0] count_t;

  count_t chan_counts [CHANNELS][BINS];
  count_t total_counts [BINS];
  pch_pkg::pch_result_t owed_results [$];
  int unsigned mismatches;

  // bin of an in-range Q1.16 sample, floor(sample * BINS)
  static function int unsigned bin_of(logic [16:0] sample);
    int unsigned scaled;
    scaled = (32'(sample) * BINS) >> pch_pkg::FRAC_W;
    return (scaled >= BINS) ? BINS - 1 : scaled;
  endfunction

  static function count_t saturating_inc(count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function int unsigned outstanding();
    return owed_results.size();
  endfunction

  // apply an accepted input transfer to the histogram and queue its result
  function void record_item(pch_pkg::pch_item_t it);
    pch_pkg::pch_result_t res;
    int unsigned bin;
    bit chan_ok;
    res = '0;
    chan_ok = it.channel < CHANNELS;
    if (it.operation == pch_pkg::OP_ADD) begin
      if (it.sample_value >= ONE_Q16) begin
        // one or more: counted nowhere
        res.out_of_range = 1'b1;
      end else begin
        bin = bin_of(it.sample_value);
        res.bin_used = 4'(bin);
        if (chan_ok) begin
          chan_counts[it.channel][bin] = saturating_inc(chan_counts[it.channel][bin]);
          total_counts[bin] = saturating_inc(total_counts[bin]);
          res.channel_count = 16'(chan_counts[it.channel][bin]);
        end
        res.total_count = 16'(total_counts[bin]);
      end
    end else begin
      res.bin_used = it.bin_index;
      if (it.bin_index < BINS) begin
        res.total_count = 16'(total_counts[it.bin_index]);
        if (chan_ok) begin
          res.channel_count = 16'(chan_counts[it.channel][it.bin_index]);
        end
      end
    end
    owed_results.push_back(res);
  endfunction

  // quiet after the first hundred reports so a broken core cannot flood the log
  function void flag(string msg);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $error("%s", msg);
    end
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      flag($sformatf("%s: expected %0d, got %0d", name, want, got));
    end
  endfunction

  // compare a result transfer with the oldest prediction
  function void check_result(pch_pkg::pch_result_t got);
    pch_pkg::pch_result_t want;
    if (owed_results.size() == 0) begin
      flag($sformatf("result with nothing owed: %p", got));
    end else begin
      want = owed_results.pop_front();
      compare_field("channel_count", want.channel_count, got.channel_count);
      compare_field("total_count", want.total_count, got.total_count);
      compare_field("bin_used", want.bin_used, got.bin_used);
      compare_field("out_of_range", want.out_of_range, got.out_of_range);
    end
  endfunction
endclass

module tb;
  import pch_pkg::*;

  localparam int BINS           = BIN_COUNT_DEF;
  localparam int CHANNELS       = CHANNEL_COUNT_DEF;
  localparam int ONE_Q16        = 1 << FRAC_W;
  localparam int RANDOM_ITEMS   = 440;
  localparam int FILL_ADDS      = 40;
  localparam int FILL_CHANNEL   = 7;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_SPARSE,
    STALL_RUNS
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  pch_item_t   item;
  logic        result_valid;
  logic        result_stall = 1'b0;
  pch_result_t result;

  hist_scoreboard sb = new();

  stall_mode_t stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned stall_run = 0;
  int unsigned quiet_cycles = 0;

  per_channel_histogram_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #10 clk = ~clk;

  // receiver back-pressure: switches between no stall, sparse stalls and stall runs
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(16, 160);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: begin
        result_stall <= 1'b0;
      end
      STALL_SPARSE: begin
        result_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (stall_run == 0 && $urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 10);
        result_stall <= (stall_run != 0);
        if (stall_run != 0) stall_run--;
      end
    endcase
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    bit took_item;
    bit took_result;
    took_item = !rst && item_valid && !item_stall;
    took_result = !rst && result_valid && !result_stall;
    if (took_item) sb.record_item(item);
    if (took_result) sb.check_result(result);
    quiet_cycles = (took_item || took_result) ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic pch_item_t make_item(logic op, int unsigned ch, int unsigned sample,
                                          int unsigned bin);
    pch_item_t it;
    it.operation = op;
    it.channel = 4'(ch);
    it.sample_value = 17'(sample);
    it.bin_index = 4'(bin);
    return it;
  endfunction

  // random transfer; often revisits the previous bin to exercise read-after-update
  function automatic pch_item_t random_item(pch_item_t prev);
    pch_item_t it;
    int unsigned k;
    it.operation = ($urandom_range(0, 99) < 60) ? OP_ADD : OP_READ;
    if ($urandom_range(0, 3) == 0 && prev.sample_value < ONE_Q16) begin
      it.channel = prev.channel;
      it.sample_value = prev.sample_value;
      it.bin_index = 4'(sb.bin_of(prev.sample_value));
    end else begin
      it.channel = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, CHANNELS - 1))
                                                : 4'($urandom_range(CHANNELS, 15));
      case ($urandom_range(0, 19))
        0, 1: it.sample_value = 17'($urandom_range(ONE_Q16, 2 * ONE_Q16 - 1));
        2: begin
          // just either side of a bin edge
          k = $urandom_range(1, BINS);
          it.sample_value = 17'((k * ONE_Q16 + BINS - 1) / BINS - $urandom_range(0, 1));
        end
        default: it.sample_value = 17'($urandom_range(0, ONE_Q16 - 1));
      endcase
      it.bin_index = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, BINS - 1))
                                                  : 4'($urandom_range(BINS, 15));
    end
    return it;
  endfunction

  // present one transfer and hold it until taken
  task automatic send_item(pch_item_t it);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic hold_until_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    pch_item_t prev;
    pch_item_t nxt;
    int unsigned sent;
    bit drained_once;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: bin edges, out-of-range samples, absent channels and bins
    send_item(make_item(OP_ADD, 0, 0, 0));
    send_item(make_item(OP_ADD, 0, 6553, 0));
    send_item(make_item(OP_ADD, 0, 6554, 0));
    send_item(make_item(OP_ADD, 11, 65535, 0));
    send_item(make_item(OP_ADD, 11, 58982, 9));
    send_item(make_item(OP_ADD, 11, 58983, 9));
    send_item(make_item(OP_ADD, 0, 65536, 0));
    send_item(make_item(OP_ADD, 11, 131071, 15));
    send_item(make_item(OP_ADD, 12, 32768, 5));
    send_item(make_item(OP_ADD, 15, 65535, 9));
    send_item(make_item(OP_ADD, 15, 131071, 15));
    send_item(make_item(OP_READ, 0, 0, 0));
    send_item(make_item(OP_READ, 0, 0, 1));
    send_item(make_item(OP_READ, 11, 0, 9));
    send_item(make_item(OP_READ, 12, 0, 9));
    send_item(make_item(OP_READ, 15, 0, 0));
    send_item(make_item(OP_READ, 0, 0, 10));
    send_item(make_item(OP_READ, 15, 0, 15));
    send_item(make_item(OP_READ, 11, 0, 15));
    send_item(make_item(OP_READ, 5, 131071, 3));
    send_item(make_item(OP_ADD, 5, 65535, 15));
    // back-to-back updates of one bin, then read it
    send_item(make_item(OP_ADD, 3, 30000, 0));
    send_item(make_item(OP_ADD, 3, 30000, 0));
    send_item(make_item(OP_READ, 3, 0, 4));

    // pile repeated adds onto one channel bin and its global bin
    repeat (FILL_ADDS) begin
      send_item(make_item(OP_ADD, FILL_CHANNEL, $urandom_range(58983, ONE_Q16 - 1),
                          $urandom_range(0, 15)));
    end
    send_item(make_item(OP_READ, FILL_CHANNEL, 0, BINS - 1));
    send_item(make_item(OP_ADD, FILL_CHANNEL, 65535, 0));
    send_item(make_item(OP_ADD, 15, 60000, 0));

    // random bursts with random gaps, and at least one full drain
    prev = '0;
    sent = 0;
    drained_once = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      repeat ($urandom_range(1, 30)) begin
        nxt = random_item(prev);
        send_item(nxt);
        prev = nxt;
        sent++;
      end
      if ((!drained_once && sent >= RANDOM_ITEMS / 2) || $urandom_range(0, 49) == 0) begin
        hold_until_drained();
        drained_once = 1'b1;
      end else if ($urandom_range(0, 2) != 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end

    // wind down and report
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
